FILE: design/service_queue_latency_monitor_top_assert.svh
// assertion macros for the queue monitor, sampled on clk and masked in reset
`ifndef SERVICE_QUEUE_LATENCY_MONITOR_TOP_ASSERT_SVH
`define SERVICE_QUEUE_LATENCY_MONITOR_TOP_ASSERT_SVH

// condition in the same cycle
`define SQLM_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition in the next cycle
`define SQLM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/sqlm_pkg.sv
package sqlm_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int WAIT_W = 16;
  localparam int SVC_W = 8;
  localparam int REC_W = 16;
  localparam int SUM_W = 32;

  localparam logic [REC_W-1:0] MIN_RESET = 16'd2000;
  localparam logic [REC_W-1:0] STAMP_NONE = 16'hFFFF;

  localparam logic FUNC_TICK = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [3:0] STAT_ARRIVALS   = 4'd0;
  localparam logic [3:0] STAT_WAIT_SUM   = 4'd1;
  localparam logic [3:0] STAT_SVC_SUM    = 4'd2;
  localparam logic [3:0] STAT_OCC_SUM    = 4'd3;
  localparam logic [3:0] STAT_WAIT_MAX   = 4'd4;
  localparam logic [3:0] STAT_WAIT_MAX_T = 4'd5;
  localparam logic [3:0] STAT_WAIT_MIN   = 4'd6;
  localparam logic [3:0] STAT_WAIT_MIN_T = 4'd7;
  localparam logic [3:0] STAT_TOT_MAX    = 4'd8;
  localparam logic [3:0] STAT_TOT_MAX_T  = 4'd9;
  localparam logic [3:0] STAT_TOT_MIN    = 4'd10;
  localparam logic [3:0] STAT_TOT_MIN_T  = 4'd11;
  localparam logic [3:0] STAT_OCC_MAX    = 4'd12;
  localparam logic [3:0] STAT_OCC_MAX_T  = 4'd13;
  localparam logic [3:0] STAT_OCC_MIN    = 4'd14;
  localparam logic [3:0] STAT_OCC_MIN_T  = 4'd15;

  typedef struct packed {
    logic [SVC_W-1:0]  rem;
    logic [SVC_W-1:0]  orig;
    logic [WAIT_W-1:0] age;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic dec;
    logic age_up;
  } cell_ctl_t;

  typedef struct packed {
    logic              acc;
    logic              serve;
    logic              adv;
    logic [REC_W-1:0]  w;
    logic [REC_W-1:0]  tot;
    logic [WAIT_W:0]   tot_full;
    logic [CNT_W-1:0]  occ;
    logic [REC_W-1:0]  now;
  } stat_evt_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? '1 : s[SUM_W-1:0];
  endfunction

endpackage

FILE: design/sqlm_cell.sv
module sqlm_cell
  import sqlm_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    ins,
  input  entry_t    nb,
  output entry_t    cur
);

  entry_t stored, stored_next;

  // arrival lands in this cell before the head is examined
  assign cur = ctl.load ? ins : stored;

  always_comb begin
    stored_next = cur;
    if (ctl.shift) begin
      stored_next = nb;
    end else begin
      if (ctl.dec) begin
        stored_next.rem = cur.rem - SVC_W'(1);
      end
      if (ctl.age_up && (cur.age != '1)) begin
        stored_next.age = cur.age + WAIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    stored <= stored_next;
  end

endmodule

FILE: design/sqlm_stats.sv
module sqlm_stats
  import sqlm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  stat_evt_t        evt,
  input  logic [3:0]       sel,
  output logic [SUM_W-1:0] stat
);

  logic [SUM_W-1:0] arrivals, wait_sum, svc_sum, occ_sum;
  logic [REC_W-1:0] max_rec [3];
  logic [REC_W-1:0] min_rec [3];
  logic [REC_W-1:0] stamp   [6];
  logic [REC_W-1:0] rec_val [3];
  logic             rec_en  [3];

  // record 0 wait, 1 wait plus service, 2 occupancy
  assign rec_val[0] = evt.w;
  assign rec_val[1] = evt.tot;
  assign rec_val[2] = REC_W'(evt.occ);
  assign rec_en[0]  = evt.serve;
  assign rec_en[1]  = evt.serve;
  assign rec_en[2]  = evt.adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      arrivals <= '0;
      wait_sum <= '0;
      svc_sum  <= '0;
      occ_sum  <= '0;
      for (int k = 0; k < 3; k++) begin
        max_rec[k]       <= '0;
        min_rec[k]       <= MIN_RESET;
        stamp[2 * k]     <= STAMP_NONE;
        stamp[2 * k + 1] <= STAMP_NONE;
      end
    end else begin
      if (evt.acc) begin
        arrivals <= sat_add(arrivals, SUM_W'(1));
      end
      if (evt.serve) begin
        wait_sum <= sat_add(wait_sum, SUM_W'(evt.w));
        // the sum takes the full wait plus service, only the records are clipped
        svc_sum  <= sat_add(svc_sum, SUM_W'(evt.tot_full));
      end
      if (evt.adv) begin
        occ_sum <= sat_add(occ_sum, SUM_W'(evt.occ));
      end
      for (int k = 0; k < 3; k++) begin
        if (rec_en[k] && (rec_val[k] > max_rec[k])) begin
          max_rec[k]   <= rec_val[k];
          stamp[2 * k] <= evt.now;
        end
        if (rec_en[k] && (rec_val[k] < min_rec[k])) begin
          min_rec[k]       <= rec_val[k];
          stamp[2 * k + 1] <= evt.now;
        end
      end
    end
  end

  always_comb begin
    stat = '0;
    unique case (sel)
      STAT_ARRIVALS:   stat = arrivals;
      STAT_WAIT_SUM:   stat = wait_sum;
      STAT_SVC_SUM:    stat = svc_sum;
      STAT_OCC_SUM:    stat = occ_sum;
      STAT_WAIT_MAX:   stat = SUM_W'(max_rec[0]);
      STAT_WAIT_MAX_T: stat = SUM_W'(stamp[0]);
      STAT_WAIT_MIN:   stat = SUM_W'(min_rec[0]);
      STAT_WAIT_MIN_T: stat = SUM_W'(stamp[1]);
      STAT_TOT_MAX:    stat = SUM_W'(max_rec[1]);
      STAT_TOT_MAX_T:  stat = SUM_W'(stamp[2]);
      STAT_TOT_MIN:    stat = SUM_W'(min_rec[1]);
      STAT_TOT_MIN_T:  stat = SUM_W'(stamp[3]);
      STAT_OCC_MAX:    stat = SUM_W'(max_rec[2]);
      STAT_OCC_MAX_T:  stat = SUM_W'(stamp[4]);
      STAT_OCC_MIN:    stat = SUM_W'(min_rec[2]);
      STAT_OCC_MIN_T:  stat = SUM_W'(stamp[5]);
    endcase
  end

endmodule

FILE: design/service_queue_latency_monitor_top.sv
// result: the result of a transaction is registered and appears in the cycle after start, marked by done
// throughput: one transaction per cycle, busy stays low; each cell of the entry chain
// updates its own entry in that cycle
// reset: synchronous, clears the entry count, sums and records; entry contents are not
// cleared, the count alone marks which cells hold entries
module service_queue_latency_monitor_top
  import sqlm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              func,
  input  logic              arrive,
  input  logic [SVC_W-1:0]  service_time,
  input  logic [REC_W-1:0]  now_time,
  input  logic [3:0]        stat_index,
  output logic              done,
  output logic              accepted,
  output logic              dropped,
  output logic              served,
  output logic [REC_W-1:0]  served_wait,
  output logic [REC_W-1:0]  served_total,
  output logic [CNT_W-1:0]  occupancy,
  output logic [SUM_W-1:0]  stat_value
);

  logic             tick, read, acc, any, serve, adv;
  logic [CNT_W-1:0] cnt, cnt_a, cnt_next;
  entry_t           ins, head;
  entry_t           cur [QUEUE_DEPTH];
  cell_ctl_t        ctl [QUEUE_DEPTH];
  logic [WAIT_W:0]  tot_full;
  logic [REC_W-1:0] w16, tot16;
  stat_evt_t        evt;
  logic [SUM_W-1:0] stat;

  assign busy  = 1'b0;
  assign tick  = start && (func == FUNC_TICK);
  assign read  = start && (func == FUNC_READ);
  assign acc   = tick && arrive && (cnt != CNT_W'(QUEUE_DEPTH));
  assign cnt_a = cnt + CNT_W'(acc);
  assign head  = cur[0];
  assign any   = (cnt_a != '0);
  assign serve = tick && any && (head.rem == '0);
  assign adv   = tick && any && (head.rem != '0);
  assign cnt_next = cnt_a - CNT_W'(serve);

  assign ins = '{rem: service_time, orig: service_time, age: '0};

  // chain of entries, cell 0 is the head; a service shifts everything one cell forward
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t nb;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign nb = cur[i];
    end else begin : g_mid
      assign nb = cur[i + 1];
    end
    assign ctl[i].load   = acc && (cnt == CNT_W'(i));
    assign ctl[i].shift  = serve;
    assign ctl[i].dec    = adv && (i == 0);
    // cells past the tail age too, their contents are reloaded on arrival
    assign ctl[i].age_up = adv && (i != 0);
    sqlm_cell u_cell (
      .clk (clk),
      .ctl (ctl[i]),
      .ins (ins),
      .nb  (nb),
      .cur (cur[i])
    );
  end

  assign tot_full = {1'b0, head.age} + (WAIT_W + 1)'(head.orig);
  assign w16      = head.age;
  assign tot16    = tot_full[WAIT_W] ? '1 : tot_full[WAIT_W-1:0];

  assign evt = '{acc: acc, serve: serve, adv: adv, w: w16, tot: tot16,
                 tot_full: tot_full, occ: cnt_a, now: now_time};

  sqlm_stats u_stats (
    .clk  (clk),
    .rst  (rst),
    .evt  (evt),
    .sel  (stat_index),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      cnt  <= cnt_next;
      done <= start;
    end
  end

  always_ff @(posedge clk) begin
    accepted     <= acc;
    dropped      <= tick && arrive && !acc;
    served       <= serve;
    served_wait  <= serve ? w16 : '0;
    served_total <= serve ? tot16 : '0;
    occupancy    <= cnt_next;
    stat_value   <= read ? stat : '0;
  end

`include "service_queue_latency_monitor_top_assert.svh"

  `SQLM_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= CNT_W'(QUEUE_DEPTH), "entry count past depth")
  `SQLM_ASSERT_NOW(a_acc_drop, done, !(accepted && dropped), "arrival both taken and dropped")
  `SQLM_ASSERT_NOW(a_total_ge, served, served_total >= served_wait, "total below wait")
  `SQLM_ASSERT_NEXT(a_done, start && !busy, done, "transaction without result")

endmodule

FILE: tb/tb_service_queue_latency_monitor_top.sv
module tb_service_queue_latency_monitor_top;
  import sqlm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic             func;
    logic             arrive;
    logic [SVC_W-1:0] svc;
    logic [REC_W-1:0] now;
    logic [3:0]       sel;
  } txn_t;

  typedef struct packed {
    logic             acc;
    logic             drop;
    logic             srv;
    logic [REC_W-1:0] s_wait;
    logic [REC_W-1:0] s_total;
    logic [CNT_W-1:0] occ;
    logic [SUM_W-1:0] stat;
  } outcome_t;

  typedef struct packed {
    txn_t     t;
    logic     known;
    outcome_t want;
  } plan_row_t;

  localparam outcome_t QUIET = '0;
  localparam outcome_t READ_MIN_RST = '{1'b0, 1'b0, 1'b0, '0, '0, '0, {16'd0, MIN_RESET}};
  localparam outcome_t READ_NO_STAMP = '{1'b0, 1'b0, 1'b0, '0, '0, '0, {16'd0, STAMP_NONE}};
  localparam outcome_t ZERO_SVC_OUT = '{1'b1, 1'b0, 1'b1, '0, '0, '0, '0};
  localparam int PLAN_LEN = 25;
  localparam int PHASE_ITEMS = 434;

  // short directed walk: reset values, ignored arrival on a read, zero service, extremes
  localparam plan_row_t PLAN [PLAN_LEN] = '{
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_ARRIVALS}, 1'b1, QUIET},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_WAIT_MIN}, 1'b1, READ_MIN_RST},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_OCC_MIN_T}, 1'b1, READ_NO_STAMP},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_TOT_MAX}, 1'b1, QUIET},
    '{'{FUNC_TICK, 1'b0, 8'd0, 16'd100, STAT_ARRIVALS}, 1'b1, QUIET},
    '{'{FUNC_READ, 1'b1, 8'd255, 16'd0, STAT_ARRIVALS}, 1'b1, QUIET},
    '{'{FUNC_TICK, 1'b1, 8'd0, 16'd0, STAT_ARRIVALS}, 1'b1, ZERO_SVC_OUT},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_WAIT_MIN}, 1'b1, QUIET},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_WAIT_MIN_T}, 1'b1, QUIET},
    '{'{FUNC_TICK, 1'b1, 8'd255, 16'd65534, STAT_OCC_MAX}, 1'b0, QUIET},
    '{'{FUNC_TICK, 1'b1, 8'd2, 16'd1, STAT_OCC_MAX}, 1'b0, QUIET},
    '{'{FUNC_TICK, 1'b1, 8'd0, 16'hAAAA, STAT_OCC_MAX}, 1'b0, QUIET},
    '{'{FUNC_TICK, 1'b0, 8'd0, 16'h5555, STAT_OCC_MAX}, 1'b0, QUIET},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_WAIT_SUM}, 1'b0, QUIET},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_SVC_SUM}, 1'b0, QUIET},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_OCC_SUM}, 1'b0, QUIET},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_WAIT_MAX}, 1'b0, QUIET},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_WAIT_MAX_T}, 1'b0, QUIET},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_TOT_MAX_T}, 1'b0, QUIET},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_TOT_MIN}, 1'b0, QUIET},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_TOT_MIN_T}, 1'b0, QUIET},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_OCC_MAX}, 1'b0, QUIET},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_OCC_MAX_T}, 1'b0, QUIET},
    '{'{FUNC_READ, 1'b0, 8'd0, 16'd0, STAT_OCC_MIN}, 1'b0, QUIET},
    '{'{FUNC_TICK, 1'b0, 8'd0, 16'd7, STAT_ARRIVALS}, 1'b0, QUIET}
  };

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic             func;
  logic             arrive;
  logic [SVC_W-1:0] service_time;
  logic [REC_W-1:0] now_time;
  logic [3:0]       stat_index;
  logic             done;
  logic             accepted;
  logic             dropped;
  logic             served;
  logic [REC_W-1:0] served_wait;
  logic [REC_W-1:0] served_total;
  logic [CNT_W-1:0] occupancy;
  logic [SUM_W-1:0] stat_value;

  service_queue_latency_monitor_top dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .func(func), .arrive(arrive), .service_time(service_time),
    .now_time(now_time), .stat_index(stat_index),
    .done(done), .accepted(accepted), .dropped(dropped), .served(served),
    .served_wait(served_wait), .served_total(served_total),
    .occupancy(occupancy), .stat_value(stat_value)
  );

  // queue model state
  logic [SVC_W-1:0]  q_rem  [QUEUE_DEPTH];
  logic [SVC_W-1:0]  q_orig [QUEUE_DEPTH];
  logic [WAIT_W-1:0] q_wait [QUEUE_DEPTH];
  int unsigned       q_count;
  int unsigned       q_head;
  logic [SUM_W-1:0]  n_arrivals;
  logic [SUM_W-1:0]  sum_wait;
  logic [SUM_W-1:0]  sum_total;
  logic [SUM_W-1:0]  sum_occ;
  logic [REC_W-1:0]  rec_max   [3];
  logic [REC_W-1:0]  rec_min   [3];
  logic [REC_W-1:0]  rec_stamp [6];

  outcome_t    pending_results[$];
  int          mismatches = 0;
  int          gap_pct = 0;
  int          n_items = 0;
  int          n_served = 0;
  int          n_dropped = 0;
  int          n_reads = 0;
  int unsigned peak_occ = 0;

  function automatic logic [SUM_W-1:0] clamp_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
    return (a > ('1 - b)) ? '1 : a + b;
  endfunction

  function automatic logic [REC_W-1:0] clamp16(input logic [SUM_W-1:0] v);
    return (v > 32'hFFFF) ? '1 : v[REC_W-1:0];
  endfunction

  // k: 0 wait, 1 wait plus service, 2 occupancy
  function automatic void note_extreme(input int k, input logic [REC_W-1:0] v,
                                       input logic [REC_W-1:0] stamp);
    if (v > rec_max[k]) begin
      rec_max[k] = v;
      rec_stamp[2*k] = stamp;
    end
    if (v < rec_min[k]) begin
      rec_min[k] = v;
      rec_stamp[2*k+1] = stamp;
    end
  endfunction

  function automatic outcome_t queue_step(input txn_t t);
    outcome_t         o;
    int unsigned      slot;
    logic [SUM_W-1:0] w;
    logic [SUM_W-1:0] tot;
    o = '0;
    if (t.func == FUNC_READ) begin
      case (t.sel)
        STAT_ARRIVALS:   o.stat = n_arrivals;
        STAT_WAIT_SUM:   o.stat = sum_wait;
        STAT_SVC_SUM:    o.stat = sum_total;
        STAT_OCC_SUM:    o.stat = sum_occ;
        STAT_WAIT_MAX:   o.stat = SUM_W'(rec_max[0]);
        STAT_WAIT_MAX_T: o.stat = SUM_W'(rec_stamp[0]);
        STAT_WAIT_MIN:   o.stat = SUM_W'(rec_min[0]);
        STAT_WAIT_MIN_T: o.stat = SUM_W'(rec_stamp[1]);
        STAT_TOT_MAX:    o.stat = SUM_W'(rec_max[1]);
        STAT_TOT_MAX_T:  o.stat = SUM_W'(rec_stamp[2]);
        STAT_TOT_MIN:    o.stat = SUM_W'(rec_min[1]);
        STAT_TOT_MIN_T:  o.stat = SUM_W'(rec_stamp[3]);
        STAT_OCC_MAX:    o.stat = SUM_W'(rec_max[2]);
        STAT_OCC_MAX_T:  o.stat = SUM_W'(rec_stamp[4]);
        STAT_OCC_MIN:    o.stat = SUM_W'(rec_min[2]);
        default:         o.stat = SUM_W'(rec_stamp[5]);
      endcase
    end else begin
      if (t.arrive) begin
        if (q_count >= QUEUE_DEPTH) begin
          o.drop = 1'b1;
        end else begin
          slot = (q_head + q_count) % QUEUE_DEPTH;
          q_rem[slot] = t.svc;
          q_orig[slot] = t.svc;
          q_wait[slot] = '0;
          q_count++;
          n_arrivals = clamp_add(n_arrivals, 1);
          o.acc = 1'b1;
        end
      end
      if (q_count > 0) begin
        if (q_rem[q_head] == '0) begin
          w = SUM_W'(q_wait[q_head]);
          tot = w + SUM_W'(q_orig[q_head]);
          sum_wait = clamp_add(sum_wait, w);
          sum_total = clamp_add(sum_total, tot);
          note_extreme(0, clamp16(w), t.now);
          note_extreme(1, clamp16(tot), t.now);
          o.srv = 1'b1;
          o.s_wait = clamp16(w);
          o.s_total = clamp16(tot);
          q_head = (q_head + 1) % QUEUE_DEPTH;
          q_count--;
        end else begin
          q_rem[q_head] = q_rem[q_head] - 1'b1;
          // entries behind the head age by one tick, saturating
          for (int i = 1; i < q_count; i++) begin
            slot = (q_head + i) % QUEUE_DEPTH;
            if (q_wait[slot] != '1) q_wait[slot] = q_wait[slot] + 1'b1;
          end
          sum_occ = clamp_add(sum_occ, q_count);
          note_extreme(2, clamp16(q_count), t.now);
        end
      end
    end
    o.occ = q_count[CNT_W-1:0];
    return o;
  endfunction

  task automatic issue(input txn_t t, input logic known, input outcome_t want);
    outcome_t predicted;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    func <= t.func;
    arrive <= t.arrive;
    service_time <= t.svc;
    now_time <= t.now;
    stat_index <= t.sel;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = queue_step(t);
    pending_results.push_back(known ? want : predicted);
    n_items++;
    if (predicted.srv) n_served++;
    if (predicted.drop) n_dropped++;
    if (t.func == FUNC_READ) n_reads++;
    if (q_count > peak_occ) peak_occ = q_count;
    @(negedge clk);
  endtask

  task automatic check_field(input string what, input logic [SUM_W-1:0] exp_v,
                             input logic [SUM_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d got %0d", $time, what, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_watch
    outcome_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no transaction pending, expected none got occupancy %0d",
                 $time, occupancy);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", SUM_W'(want.acc), SUM_W'(accepted));
        check_field("dropped", SUM_W'(want.drop), SUM_W'(dropped));
        check_field("served", SUM_W'(want.srv), SUM_W'(served));
        check_field("served_wait", SUM_W'(want.s_wait), SUM_W'(served_wait));
        check_field("served_total", SUM_W'(want.s_total), SUM_W'(served_total));
        check_field("occupancy", SUM_W'(want.occ), SUM_W'(occupancy));
        check_field("stat_value", want.stat, stat_value);
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    txn_t        t;
    int          base_gap;
    int          arr_pct;
    int          seg_len;
    int          issued;
    int          guard;
    int          pick;
    logic [15:0] tick_clock;
    rst = 1'b1;
    start = 1'b0;
    func = FUNC_TICK;
    arrive = 1'b0;
    service_time = '0;
    now_time = '0;
    stat_index = STAT_ARRIVALS;
    q_count = 0;
    q_head = 0;
    n_arrivals = '0;
    sum_wait = '0;
    sum_total = '0;
    sum_occ = '0;
    for (int k = 0; k < 3; k++) begin
      rec_max[k] = '0;
      rec_min[k] = MIN_RESET;
    end
    for (int k = 0; k < 6; k++) rec_stamp[k] = STAMP_NONE;
    tick_clock = 16'd8;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    gap_pct = 29;
    for (int i = 0; i < PLAN_LEN; i++) issue(PLAN[i].t, PLAN[i].known, PLAN[i].want);

    for (int phase = 0; phase < 3; phase++) begin
      base_gap = (phase == 0) ? 29 : (phase == 1) ? 63 : 0;
      issued = 0;
      while (issued < PHASE_ITEMS) begin
        // each segment is drawn at random from filling, mixed traffic and draining the queue
        case ($urandom_range(2))
          0:       arr_pct = 92;
          1:       arr_pct = 30;
          default: arr_pct = 0;
        endcase
        seg_len = $urandom_range(120, 40);
        gap_pct = base_gap;
        for (int k = 0; k < seg_len && issued < PHASE_ITEMS; k++) begin
          t.func = ($urandom_range(99) < 15) ? FUNC_READ : FUNC_TICK;
          t.arrive = ($urandom_range(99) < arr_pct);
          pick = $urandom_range(39);
          if (pick < 16) t.svc = '0;
          else if (pick < 32) t.svc = SVC_W'($urandom_range(3, 1));
          else if (pick < 38) t.svc = SVC_W'($urandom_range(20, 4));
          else if (pick == 38) t.svc = SVC_W'($urandom_range(255));
          else t.svc = 8'd255;
          if ($urandom_range(19) == 0)
            t.now = $urandom_range(1) ? 16'd65534 : 16'($urandom_range(65534));
          else
            t.now = tick_clock;
          if (t.func == FUNC_TICK)
            tick_clock = (tick_clock == 16'd65534) ? 16'd0 : tick_clock + 1'b1;
          t.sel = 4'($urandom_range(15));
          issue(t, 1'b0, QUIET);
          issued++;
        end
      end
    end
    start <= 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < 1000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d transactions never produced a result",
               $time, pending_results.size());
      mismatches++;
    end

    $display("ran %0d transactions (%0d statistic reads) through the queue", n_items, n_reads);
    $display("%0d entries served, %0d arrivals refused, peak occupancy %0d",
             n_served, n_dropped, peak_occ);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
